### rtl/core/log2_histogram_percentile_top_assert.svh
// ---------------------------------------------------------------------------
// Histogram percentile assertion macros
// Concurrent check macros used by the top level; they sample on clk
// and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LOG2_HISTOGRAM_PERCENTILE_TOP_ASSERT_SVH
`define LOG2_HISTOGRAM_PERCENTILE_TOP_ASSERT_SVH

// Same-cycle implication.
`define HLP_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HLP_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hlp_pkg.sv
// ---------------------------------------------------------------------------
// Histogram percentile package
// Shared types, constants and helpers of the log2 histogram percentile block.
// ---------------------------------------------------------------------------
`default_nettype none

package hlp_pkg;

  localparam int VAL_W  = 32;
  localparam int PCT_W  = 7;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VAL_W-1:0]  value;
    logic [PCT_W-1:0]  pct;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] x);
    sat_inc = (x == ALL_ONES) ? x : x + 1'b1;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hlp_queue.sv
// ---------------------------------------------------------------------------
// Histogram percentile command queue
// Short FIFO between the classifying front and the executing back.
// ---------------------------------------------------------------------------
`default_nettype none

module hlp_queue import hlp_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output qstat_t            qstat,
  output logic   [W-1:0]    pop_data
);

  logic [W-1:0]      ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign qstat.valid = (cnt_r != '0);
  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_data    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hlp_front.sv
// ---------------------------------------------------------------------------
// Histogram percentile front end
// Accepts transactions, finds the log2 bucket of each sample and queues work.
// ---------------------------------------------------------------------------
`default_nettype none

module hlp_front import hlp_pkg::*; #(
  parameter  int BUCKETS = 32,
  localparam int BIDX_W  = $clog2(BUCKETS)
) (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_command,
  input  wire logic [VAL_W-1:0]  in_sample_value,
  input  wire logic [PCT_W-1:0]  in_percent,
  input  wire qstat_t            qstat,
  output logic                   push,
  output item_t                  push_item,
  output logic [BIDX_W-1:0]      push_bkt
);

  logic [4:0] lg;
  logic       known_cmd;

  assign in_stall = qstat.full;

  // Position of the highest set bit.
  always_comb begin
    lg = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (in_sample_value[i]) begin
        lg = 5'(i);
      end
    end
  end

  always_comb begin
    if (in_sample_value == '0) begin
      push_bkt = '0;
    end else if (32'(lg) >= 32'(BUCKETS - 2)) begin
      push_bkt = BIDX_W'(BUCKETS - 1);
    end else begin
      push_bkt = BIDX_W'(32'(lg) + 32'd1);
    end
  end

  always_comb begin
    case (in_command)
      CMD_RECORD, CMD_QUERY, CMD_CLEAR: known_cmd = 1'b1;
      default:                          known_cmd = 1'b0;
    endcase
  end

  // Drop the unused command code at the door.
  assign push            = in_valid && !qstat.full && known_cmd;
  assign push_item.cmd   = cmd_t'(in_command);
  assign push_item.value = in_sample_value;
  assign push_item.pct   = in_percent;

endmodule

`default_nettype wire

### rtl/core/hlp_back.sv
// ---------------------------------------------------------------------------
// Histogram percentile back end
// Updates the bucket store, count and maximum; walks buckets for queries.
// ---------------------------------------------------------------------------
`default_nettype none

module hlp_back import hlp_pkg::*; #(
  parameter  int BUCKETS = 32,
  localparam int BIDX_W  = $clog2(BUCKETS),
  localparam int ACC_W   = VAL_W + PCT_W + $clog2(BUCKETS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qstat_t            qstat,
  input  wire item_t             hd_item,
  input  wire logic [BIDX_W-1:0] hd_bkt,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_quantile_bound,
  output logic [VAL_W-1:0]       out_sample_total,
  output logic [VAL_W-1:0]       out_largest_sample
);

  typedef enum logic [4:0] {
    ST_RUN  = 5'b00001,
    ST_WRD  = 5'b00010,
    ST_WADD = 5'b00100,
    ST_WCHK = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  logic [VAL_W-1:0] mem [BUCKETS];

  state_t              state_r, state_nxt;
  logic [BUCKETS-1:0]  vld_r, vld_nxt;
  logic [VAL_W-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    max_r, max_nxt;
  logic [VAL_W-1:0]    rd_data_r;
  logic                rd_vld_r;
  logic                wr_act_r, wr_act_nxt;
  logic [BIDX_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic                fwd_act_r, fwd_act_nxt;
  logic [BIDX_W-1:0]   fwd_addr_r, fwd_addr_nxt;
  logic [VAL_W-1:0]    fwd_data_r, fwd_data_nxt;
  logic [BIDX_W-1:0]   idx_r, idx_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    prod_r, prod_nxt;
  logic [VAL_W-1:0]    snap_cnt_r, snap_cnt_nxt;
  logic [VAL_W-1:0]    snap_max_r, snap_max_nxt;
  logic [VAL_W-1:0]    bound_r, bound_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    oq_r, oq_nxt;
  logic [VAL_W-1:0]    ot_r, ot_nxt;
  logic [VAL_W-1:0]    om_r, om_nxt;

  logic [BIDX_W-1:0]   rd_addr;
  logic [VAL_W-1:0]    wr_cur;
  logic [VAL_W-1:0]    wr_data;
  logic [VAL_W-1:0]    eff;
  logic [ACC_W-1:0]    eff_ext;
  logic [VAL_W-1:0]    idx32;

  assign out_valid          = out_valid_r;
  assign out_quantile_bound = oq_r;
  assign out_sample_total   = ot_r;
  assign out_largest_sample = om_r;

  assign eff     = rd_vld_r ? rd_data_r : '0;
  assign eff_ext = ACC_W'(eff);
  assign idx32   = 32'(idx_r);

  // Take the value written last cycle; the read port missed it.
  assign wr_cur  = (fwd_act_r && fwd_addr_r == wr_addr_r) ? fwd_data_r : eff;
  assign wr_data = sat_inc(wr_cur);

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    wr_act_nxt    = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    fwd_act_nxt   = wr_act_r;
    fwd_addr_nxt  = wr_addr_r;
    fwd_data_nxt  = wr_data;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    snap_cnt_nxt  = snap_cnt_r;
    snap_max_nxt  = snap_max_r;
    bound_nxt     = bound_r;
    out_valid_nxt = out_valid_r;
    oq_nxt        = oq_r;
    ot_nxt        = ot_r;
    om_nxt        = om_r;
    pop           = 1'b0;
    rd_addr       = idx_r;

    if (wr_act_r) begin
      vld_nxt[wr_addr_r] = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_RUN: begin
        if (qstat.valid) begin
          case (hd_item.cmd)
            CMD_RECORD: begin
              pop         = 1'b1;
              rd_addr     = hd_bkt;
              wr_act_nxt  = 1'b1;
              wr_addr_nxt = hd_bkt;
              cnt_nxt     = sat_inc(cnt_r);
              if (hd_item.value > max_r) begin
                max_nxt = hd_item.value;
              end
            end
            CMD_QUERY: begin
              // Hold until the pending bucket write has landed.
              if (!wr_act_r) begin
                pop          = 1'b1;
                snap_cnt_nxt = cnt_r;
                snap_max_nxt = max_r;
                prod_nxt     = ACC_W'(cnt_r) * ACC_W'(hd_item.pct);
                idx_nxt      = '0;
                acc_nxt      = '0;
                if (cnt_r == '0 || hd_item.pct == '0) begin
                  bound_nxt = '0;
                  state_nxt = ST_DONE;
                end else begin
                  state_nxt = ST_WRD;
                end
              end
            end
            CMD_CLEAR: begin
              if (!wr_act_r) begin
                pop     = 1'b1;
                vld_nxt = '0;
                cnt_nxt = '0;
                max_nxt = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_WRD: begin
        rd_addr   = idx_r;
        state_nxt = ST_WADD;
      end
      ST_WADD: begin
        acc_nxt   = acc_r + (eff_ext << 6) + (eff_ext << 5) + (eff_ext << 2);
        state_nxt = ST_WCHK;
      end
      ST_WCHK: begin
        // 100 * running sum >= count * percent is the ceil-rank test.
        if (acc_r >= prod_r) begin
          if (idx_r == '0) begin
            bound_nxt = '0;
          end else if (idx32 >= 32'(BUCKETS - 1) || idx32 >= 32'(VAL_W)) begin
            bound_nxt = ALL_ONES;
          end else begin
            bound_nxt = ~(ALL_ONES << idx32[4:0]);
          end
          state_nxt = ST_DONE;
        end else if (idx_r == BIDX_W'(BUCKETS - 1)) begin
          bound_nxt = ALL_ONES;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_WRD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          oq_nxt        = bound_r;
          ot_nxt        = snap_cnt_r;
          om_nxt        = snap_max_r;
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      vld_r       <= '0;
      cnt_r       <= '0;
      max_r       <= '0;
      wr_act_r    <= 1'b0;
      fwd_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      wr_act_r    <= wr_act_nxt;
      fwd_act_r   <= fwd_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    snap_cnt_r <= snap_cnt_nxt;
    snap_max_r <= snap_max_nxt;
    bound_r    <= bound_nxt;
    oq_r       <= oq_nxt;
    ot_r       <= ot_nxt;
    om_r       <= om_nxt;
  end

  // Bucket store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_act_r) begin
      mem[wr_addr_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/log2_histogram_percentile_top.sv
// ---------------------------------------------------------------------------
// Log2 histogram percentile estimator, top level
// Record: one transaction per cycle while in_stall is low; the bucket store is written
// from the registered write request after the back end pops the record. Query: the
// back end walks the buckets with one read, add and check step per bucket (ST_WRD,
// ST_WADD, ST_WCHK), then ST_DONE presents the result; query and clear wait for a pending write.
// Reset: synchronous; control, count, maximum and bucket valid bits cleared.
// ---------------------------------------------------------------------------
`default_nettype none
`include "log2_histogram_percentile_top_assert.svh"

module log2_histogram_percentile_top import hlp_pkg::*; #(
  parameter int BUCKETS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_command,
  input  wire logic [VAL_W-1:0]  in_sample_value,
  input  wire logic [PCT_W-1:0]  in_percent,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       out_quantile_bound,
  output logic [VAL_W-1:0]       out_sample_total,
  output logic [VAL_W-1:0]       out_largest_sample
);

  localparam int BIDX_W = $clog2(BUCKETS);
  localparam int QW     = ITEM_W + BIDX_W;

  qstat_t            qstat;
  logic              q_push;
  logic              q_pop;
  item_t             push_item;
  logic [BIDX_W-1:0] push_bkt;
  logic [QW-1:0]     q_head;

  hlp_front #(.BUCKETS(BUCKETS)) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_sample_value (in_sample_value),
    .in_percent      (in_percent),
    .qstat           (qstat),
    .push            (q_push),
    .push_item       (push_item),
    .push_bkt        (push_bkt)
  );

  hlp_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_item, push_bkt}),
    .pop       (q_pop),
    .qstat     (qstat),
    .pop_data  (q_head)
  );

  hlp_back #(.BUCKETS(BUCKETS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .qstat              (qstat),
    .hd_item            (q_head[QW-1:BIDX_W]),
    .hd_bkt             (q_head[BIDX_W-1:0]),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quantile_bound (out_quantile_bound),
    .out_sample_total   (out_sample_total),
    .out_largest_sample (out_largest_sample)
  );

  `HLP_CHK_IMPL(a_no_push_full, q_push, !qstat.full, "queue push while full")
  `HLP_CHK_IMPL(a_no_pop_empty, q_pop, qstat.valid, "queue pop while empty")
  `HLP_CHK_NEXT(a_full_holds, qstat.full && !q_pop, qstat.full, "queue lost an entry")

endmodule

`default_nettype wire

### verif/log2_histogram_percentile_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Log2 histogram percentile checker
// Watches both channels of the histogram block and keeps its own copy of the
// bucket store, sample count and maximum. Every accepted query pushes the
// predicted report. Every accepted result is compared against the oldest
// predicted report, and the checker counts any mismatch.
// ---------------------------------------------------------------------------
module log2_histogram_percentile_checker import hlp_pkg::*; #(
  parameter int BUCKETS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_command,
  input  logic [VAL_W-1:0] in_sample_value,
  input  logic [PCT_W-1:0] in_percent,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [VAL_W-1:0] out_quantile_bound,
  input  logic [VAL_W-1:0] out_sample_total,
  input  logic [VAL_W-1:0] out_largest_sample,
  output int               mismatches,
  output int               outstanding
);

  localparam logic [63:0] PCT_SCALE = 64'd100;
  localparam int          MAX_SHOWN = 10;

  typedef struct packed {
    logic [VAL_W-1:0] bound;
    logic [VAL_W-1:0] total;
    logic [VAL_W-1:0] largest;
  } report_t;

  logic [VAL_W-1:0] bucket_tally [BUCKETS];
  logic [VAL_W-1:0] sample_tally;
  logic [VAL_W-1:0] peak_sample;
  report_t          expected_reports [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [VAL_W-1:0] bump(input logic [VAL_W-1:0] x);
    return (x == ALL_ONES) ? x : x + 1'b1;
  endfunction

  function automatic int unsigned bucket_index(input logic [VAL_W-1:0] v);
    int unsigned lg;
    lg = 0;
    if (v == '0) return 0;
    for (int i = 0; i < VAL_W; i++) begin
      if (v[i]) lg = i;
    end
    if (lg > BUCKETS - 2) lg = BUCKETS - 2;
    return lg + 1;
  endfunction

  function automatic logic [VAL_W-1:0] percentile_bound(input logic [PCT_W-1:0] pct);
    logic [63:0] rank;
    logic [63:0] running;
    if (sample_tally == '0 || pct == '0) return '0;
    rank = (64'(sample_tally) * 64'(pct) + PCT_SCALE - 1) / PCT_SCALE;
    if (rank == 0) rank = 1;
    running = 0;
    for (int b = 0; b < BUCKETS; b++) begin
      running += 64'(bucket_tally[b]);
      if (running >= rank) begin
        if (b == 0) return '0;
        if (b >= BUCKETS - 1 || b >= VAL_W) return ALL_ONES;
        return VAL_W'((64'd1 << b) - 1);
      end
    end
    // rank beyond the total: percent above a hundred
    return ALL_ONES;
  endfunction

  function automatic void clear_store();
    for (int b = 0; b < BUCKETS; b++) bucket_tally[b] = '0;
    sample_tally = '0;
    peak_sample  = '0;
  endfunction

  always @(posedge clk) begin : monitor
    report_t     got;
    report_t     want;
    int unsigned idx;
    if (!rst_n) begin
      clear_store();
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_command == CMD_RECORD) begin
          idx = bucket_index(in_sample_value);
          bucket_tally[idx] = bump(bucket_tally[idx]);
          sample_tally = bump(sample_tally);
          if (in_sample_value > peak_sample) peak_sample = in_sample_value;
        end else if (in_command == CMD_QUERY) begin
          want.bound   = percentile_bound(in_percent);
          want.total   = sample_tally;
          want.largest = peak_sample;
          expected_reports.push_back(want);
        end else if (in_command == CMD_CLEAR) begin
          clear_store();
        end
        // unused command: drop
      end
      if (out_valid && !out_stall) begin
        got.bound   = out_quantile_bound;
        got.total   = out_sample_total;
        got.largest = out_largest_sample;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result transaction: bound %h total %h largest %h",
                     got.bound, got.total, got.largest);
        end else begin
          want = expected_reports.pop_front();
          if (got.bound != want.bound || got.total != want.total ||
              got.largest != want.largest) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("result mismatch: bound exp %h got %h, total exp %h got %h, largest exp %h got %h",
                       want.bound, got.bound, want.total, got.total,
                       want.largest, got.largest);
          end
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

### verif/tb_log2_histogram_percentile_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Log2 histogram percentile testbench
// Drives directed and random record, query, clear and unused transactions into the
// histogram block with random gaps on both channels; the checker predicts
// each query report and compares it against the block's results.
// ---------------------------------------------------------------------------
module tb_log2_histogram_percentile_top;
  import hlp_pkg::*;

  localparam int          BUCKETS      = 32;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          DRAIN_CYCLES = 3 * BUCKETS + 60;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic [1:0]       in_command      = CMD_RECORD;
  logic [VAL_W-1:0] in_sample_value = '0;
  logic [PCT_W-1:0] in_percent      = '0;
  logic             out_stall       = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [VAL_W-1:0] out_quantile_bound;
  logic [VAL_W-1:0] out_sample_total;
  logic [VAL_W-1:0] out_largest_sample;
  int               mismatches;
  int               outstanding;
  int               cycle_count     = 0;
  bit               quiet           = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  log2_histogram_percentile_top #(.BUCKETS(BUCKETS)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_sample_value    (in_sample_value),
    .in_percent         (in_percent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quantile_bound (out_quantile_bound),
    .out_sample_total   (out_sample_total),
    .out_largest_sample (out_largest_sample)
  );

  log2_histogram_percentile_checker #(.BUCKETS(BUCKETS)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_sample_value    (in_sample_value),
    .in_percent         (in_percent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quantile_bound (out_quantile_bound),
    .out_sample_total   (out_sample_total),
    .out_largest_sample (out_largest_sample),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VAL_W-1:0] random_sample();
    int          r;
    int unsigned sh;
    r  = $urandom_range(0, 99);
    sh = $urandom_range(0, VAL_W - 1);
    if (r < 8)  return '0;
    if (r < 14) return ALL_ONES;
    if (r < 24) return $urandom;
    // spread over every magnitude so all buckets fill
    return (VAL_W'($urandom) >> (VAL_W - 1 - sh)) | (VAL_W'(1) << sh);
  endfunction

  function automatic logic [PCT_W-1:0] random_percent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return 7'd50;
    if (r < 24) return 7'd90;
    if (r < 32) return 7'd99;
    if (r < 40) return 7'd100;
    if (r < 50) return PCT_W'($urandom_range(101, 127));
    return PCT_W'($urandom_range(1, 100));
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [VAL_W-1:0] value,
                           input logic [PCT_W-1:0] pct);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid        <= 1'b0;
      in_command      <= 2'($urandom);
      in_sample_value <= $urandom;
      in_percent      <= PCT_W'($urandom);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_sample_value <= value;
    in_percent      <= pct;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver side: random stall bursts between short open runs
  initial begin : result_pacing
    int burst;
    forever begin
      burst = idle_len();
      repeat (burst) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int sent;
    int r;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty histogram, then zero percent and bucket zero
    send_item(CMD_QUERY,  '0, 7'd50);
    send_item(CMD_RECORD, '0, '0);
    send_item(CMD_QUERY,  '0, 7'd0);
    send_item(CMD_QUERY,  '0, 7'd100);
    // extremes and the clamped top buckets
    send_item(CMD_RECORD, 32'h0000_0001, '0);
    send_item(CMD_RECORD, ALL_ONES, '0);
    send_item(CMD_RECORD, 32'h8000_0000, '0);
    send_item(CMD_RECORD, 32'h4000_0000, '0);
    send_item(CMD_RECORD, 32'h3FFF_FFFF, '0);
    send_item(CMD_RECORD, 32'h0000_0002, '0);
    send_item(CMD_QUERY,  '0, 7'd50);
    send_item(CMD_QUERY,  '0, 7'd90);
    send_item(CMD_QUERY,  '0, 7'd99);
    send_item(CMD_QUERY,  '0, 7'd1);
    // rank past the total
    send_item(CMD_QUERY,  ALL_ONES, 7'd127);
    send_item(CMD_UNUSED, ALL_ONES, 7'd127);
    send_item(CMD_QUERY,  '0, 7'd100);
    send_item(CMD_CLEAR,  ALL_ONES, 7'd127);
    send_item(CMD_QUERY,  '0, 7'd100);
    send_item(CMD_RECORD, 32'h0000_0005, '0);
    send_item(CMD_RECORD, 32'h3FFF_FFFF, '0);
    send_item(CMD_QUERY,  '0, 7'd99);
    send_item(CMD_QUERY,  '0, 7'd127);
    send_item(CMD_QUERY,  '0, 7'd101);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(CMD_UNUSED, $urandom, PCT_W'($urandom));
      end else begin
        sent++;
        if (r < 5)
          send_item(CMD_CLEAR, $urandom, PCT_W'($urandom));
        else if (r < 20)
          send_item(CMD_QUERY, $urandom, random_percent());
        else
          send_item(CMD_RECORD, random_sample(), PCT_W'($urandom));
      end
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
